// ===== rtl/spl_pkg.sv =====
// Package for the shard placement scheduler: codes, defaults and the queue entry type.
package spl_pkg;

    localparam int DEF_MAX_PEERS  = 16;
    localparam int DEF_MAX_SHARDS = 64;
    localparam int DEF_NUM_TYPES  = 8;

    localparam int QUEUE_DEPTH = 2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SCHED = 1'b1;

    localparam logic [1:0] PS_NONE   = 2'd0;
    localparam logic [1:0] PS_FOLLOW = 2'd1;
    localparam logic [1:0] PS_LEAD   = 2'd2;
    localparam logic [1:0] PS_SPARE  = 2'd3;

    localparam logic REG_MIN_ALIVE = 1'b0;
    localparam logic REG_USE_MASK  = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic       first;
        logic [1:0] pstate;
        logic [2:0] wtype;
        logic [6:0] count;
        logic       allowed;
    } t_entry;

endpackage

// ===== rtl/spl_front.sv =====
// Front end: accepts input items, classifies them and pushes them into the queue.
module spl_front
    import spl_pkg::*;
#(
    parameter int MAX_SHARDS = DEF_MAX_SHARDS,
    parameter int NUM_TYPES  = DEF_NUM_TYPES
) (
    input  logic        i_s_valid,
    input  logic [15:0] i_s_data,
    input  logic        i_s_user,
    input  logic [7:0]  i_use_mask,
    input  logic        i_q_full,
    output logic        o_s_ready,
    output logic        o_push,
    output t_entry      o_entry
);

    logic [6:0] w_count;
    logic [2:0] w_type;

    assign w_count = i_s_data[12:6];
    assign w_type  = i_s_data[5:3];

    assign o_s_ready = !i_q_full;

    always_comb begin
        o_entry.opcode  = i_s_user;
        o_entry.first   = i_s_data[0];
        o_entry.pstate  = i_s_data[2:1];
        o_entry.wtype   = w_type;
        o_entry.count   = (w_count > 7'(MAX_SHARDS)) ? 7'(MAX_SHARDS) : w_count;
        o_entry.allowed = (32'(w_type) < NUM_TYPES) && i_use_mask[w_type];
    end

    // zero-shard schedules are dropped here
    assign o_push = i_s_valid && !i_q_full && (i_s_user == OP_LOAD || w_count != 7'd0);

endmodule

// ===== rtl/spl_queue.sv =====
// Short queue of classified items between the front and back ends.
module spl_queue
    import spl_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_entry
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_entry          r_mem [QUEUE_DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [NW-1:0]   r_cnt;
    logic            w_push;
    logic            w_pop;

    assign o_full  = (r_cnt == NW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (32'(r_wr) == QUEUE_DEPTH - 1) ? '0 : AW'(r_wr + 1'b1);
            end
            if (w_pop) begin
                r_rd <= (32'(r_rd) == QUEUE_DEPTH - 1) ? '0 : AW'(r_rd + 1'b1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= NW'(r_cnt + 1'b1);
            end else if (w_pop && !w_push) begin
                r_cnt <= NW'(r_cnt - 1'b1);
            end
        end
    end

endmodule

// ===== rtl/spl_back.sv =====
// Back end: holds the peer tables, applies loads and steps through the shards of a schedule.
module spl_back
    import spl_pkg::*;
#(
    parameter int MAX_PEERS  = DEF_MAX_PEERS,
    parameter int MAX_SHARDS = DEF_MAX_SHARDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [4:0]  i_min_alive,
    input  logic        i_q_valid,
    input  t_entry      i_q_entry,
    output logic        o_q_pop,
    input  logic        i_m_ready,
    output logic        o_m_valid,
    output logic [2:0]  o_m_type,
    output logic [5:0]  o_m_shard,
    output logic [3:0]  o_m_peer,
    output logic        o_m_nop,
    output logic        o_m_last
);

    localparam int PW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam int CW = $clog2(MAX_PEERS + 1);
    localparam int SW = $clog2(MAX_SHARDS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_nl_cnt;
    logic [CW-1:0]   r_al_cnt;
    logic [CW-1:0]   r_load_cnt;
    logic [PW-1:0]   r_leader;
    logic            r_seen;
    logic [PW-1:0]   r_rot;

    logic [2:0]      r_type;
    logic [SW-1:0]   r_total;
    logic [SW-1:0]   r_shard;
    logic [PW-1:0]   r_slot;
    logic [PW-1:0]   r_aptr;
    logic            r_lead_mode;

    logic [PW-1:0]   m_nl_list  [MAX_PEERS];
    logic            m_nl_alive [MAX_PEERS];
    logic [PW-1:0]   m_al_list  [MAX_PEERS];
    logic [PW-1:0]   r_rd_nl;
    logic            r_rd_alv;
    logic [PW-1:0]   r_rd_al;

    logic            r_out_valid;
    logic [2:0]      r_out_type;
    logic [5:0]      r_out_shard;
    logic [3:0]      r_out_peer;
    logic            r_out_nop;
    logic            r_out_last;

    // load path
    logic [CW-1:0]   ld_nl;
    logic [CW-1:0]   ld_al;
    logic [CW-1:0]   ld_load;
    logic [PW-1:0]   ld_leader;
    logic            ld_seen;
    logic            ld_ok;
    logic [PW-1:0]   ld_idx;
    logic            ld_go;
    logic            we_nl;
    logic            we_al;

    // shard path
    logic            w_lead_cond;
    logic            w_last;
    logic            w_orphan;
    logic [PW-1:0]   w_slot_nx;
    logic [PW-1:0]   w_aptr_nx;
    logic [PW-1:0]   w_peer_sel;
    logic [PW+3:0]   w_peer_ext;
    logic [SW+5:0]   w_shard_ext;

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    always_comb begin
        ld_nl     = i_q_entry.first ? '0 : r_nl_cnt;
        ld_al     = i_q_entry.first ? '0 : r_al_cnt;
        ld_load   = i_q_entry.first ? '0 : r_load_cnt;
        ld_leader = i_q_entry.first ? '0 : r_leader;
        ld_seen   = i_q_entry.first ? 1'b0 : r_seen;
        ld_ok     = (ld_load < CW'(MAX_PEERS));
        ld_idx    = ld_load[PW-1:0];
        ld_go     = o_q_pop && (i_q_entry.opcode == OP_LOAD);
        we_nl     = ld_go && ld_ok && (i_q_entry.pstate != PS_LEAD);
        we_al     = ld_go && ld_ok && (i_q_entry.pstate == PS_FOLLOW);
    end

    always_comb begin
        w_lead_cond = !i_q_entry.allowed || (r_al_cnt == '0)
                      || (8'(r_al_cnt) < 8'(i_min_alive)) || (r_nl_cnt == '0);
        w_last      = (SW'(r_shard + 1'b1) == r_total);
        w_orphan    = !r_lead_mode && !r_rd_alv;
        w_slot_nx   = (CW'(r_slot) + 1'b1 == r_nl_cnt) ? '0 : PW'(r_slot + 1'b1);
        w_aptr_nx   = (CW'(r_aptr) + 1'b1 == r_al_cnt) ? '0 : PW'(r_aptr + 1'b1);
        if (r_lead_mode) begin
            w_peer_sel = r_seen ? r_leader : '0;
        end else begin
            w_peer_sel = r_rd_alv ? r_rd_nl : r_rd_al;
        end
        w_peer_ext  = {4'b0, w_peer_sel};
        w_shard_ext = {6'b0, r_shard};
    end

    always_ff @(posedge i_clk) begin
        if (we_nl) begin
            m_nl_list[ld_nl[PW-1:0]]  <= ld_idx;
            m_nl_alive[ld_nl[PW-1:0]] <= (i_q_entry.pstate == PS_FOLLOW);
        end
        if (we_al) begin
            m_al_list[ld_al[PW-1:0]] <= ld_idx;
        end
        r_rd_nl  <= m_nl_list[r_slot];
        r_rd_alv <= m_nl_alive[r_slot];
        r_rd_al  <= m_al_list[r_aptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nl_cnt    <= '0;
            r_al_cnt    <= '0;
            r_load_cnt  <= '0;
            r_leader    <= '0;
            r_seen      <= 1'b0;
            r_rot       <= '0;
            r_type      <= '0;
            r_total     <= '0;
            r_shard     <= '0;
            r_slot      <= '0;
            r_aptr      <= '0;
            r_lead_mode <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_type  <= '0;
            r_out_shard <= '0;
            r_out_peer  <= '0;
            r_out_nop   <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            // in S_EMIT the output register is refilled whenever it drains
            if (r_out_valid && i_m_ready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (ld_go) begin
                        r_nl_cnt   <= we_nl ? CW'(ld_nl + 1'b1) : ld_nl;
                        r_al_cnt   <= we_al ? CW'(ld_al + 1'b1) : ld_al;
                        r_load_cnt <= ld_ok ? CW'(ld_load + 1'b1) : ld_load;
                        if (ld_ok && i_q_entry.pstate == PS_LEAD) begin
                            r_leader <= ld_idx;
                            r_seen   <= 1'b1;
                        end else begin
                            r_leader <= ld_leader;
                            r_seen   <= ld_seen;
                        end
                        if (i_q_entry.first) begin
                            r_rot <= '0;
                        end
                    end else if (o_q_pop) begin
                        r_type      <= i_q_entry.wtype;
                        r_total     <= SW'(i_q_entry.count);
                        r_shard     <= '0;
                        r_slot      <= '0;
                        r_aptr      <= r_rot;
                        r_lead_mode <= w_lead_cond;
                        r_state     <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_valid || i_m_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_type  <= r_type;
                        r_out_shard <= w_shard_ext[5:0];
                        r_out_peer  <= w_peer_ext[3:0];
                        r_out_nop   <= r_lead_mode && !r_seen;
                        r_out_last  <= w_last;
                        r_shard     <= SW'(r_shard + 1'b1);
                        r_slot      <= w_slot_nx;
                        if (w_orphan) begin
                            r_aptr <= w_aptr_nx;
                        end
                        if (w_last) begin
                            if (!r_lead_mode) begin
                                r_rot <= w_orphan ? w_aptr_nx : r_aptr;
                            end
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_type  = r_out_type;
    assign o_m_shard = r_out_shard;
    assign o_m_peer  = r_out_peer;
    assign o_m_nop   = r_out_nop;
    assign o_m_last  = r_out_last;

endmodule

// ===== rtl/shard_placement_scheduler.sv =====
// Top level of the shard placement scheduler: configuration registers and the front/back split.
//
// Usage:
//   Input stream (s_axis): tuser is the opcode. A load item gives one peer's state in load
//   order, with first_peer clearing the peer tables and the rotation offset first. A schedule
//   item gives a work type and its shard count and produces one placement per shard on the
//   output stream (m_axis), tlast marking the final shard.
//   APB port: register 0 at 0x0 is min_alive_followers, register 1 at 0x4 is
//   use_followers_mask. Write only while the block is idle.
// Flow:
//   Items pass a two-entry queue into the back end, which applies a load in its idle state as it
//   pops it. In a schedule every shard passes a table read state and then an output state, the
//   table memories having registered reads. Zero-shard schedules are absorbed by the front end.
// Reset and stall:
//   Synchronous reset clears the counts, leader, offset, queue and registers. If the receiver
//   holds m_axis_tready low the result stays in the output register and the back end waits;
//   the front end keeps accepting until the queue is full.
module shard_placement_scheduler
    import spl_pkg::*;
#(
    parameter int MAX_PEERS  = DEF_MAX_PEERS,
    parameter int MAX_SHARDS = DEF_MAX_SHARDS,
    parameter int NUM_TYPES  = DEF_NUM_TYPES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] first_peer, [2:1] peer_state, [5:3] type_index, [12:6] shard_count, [15:13] zero
    input  logic [15:0] s_axis_tdata,
    // [0] opcode
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] out_type, [8:3] shard_index, [12:9] peer_index, [15:13] zero
    output logic [15:0] m_axis_tdata,
    // [0] no_peer
    output logic        m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [4:0]  r_min_alive;
    logic [7:0]  r_use_mask;

    logic        w_push;
    t_entry      w_push_entry;
    logic        w_q_full;
    logic        w_q_valid;
    t_entry      w_q_entry;
    logic        w_q_pop;

    logic [2:0]  w_type;
    logic [5:0]  w_shard;
    logic [3:0]  w_peer;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_alive <= '0;
            r_use_mask  <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_MIN_ALIVE: r_min_alive <= pwdata[4:0];
                REG_USE_MASK:  r_use_mask  <= pwdata[7:0];
                default:       r_use_mask  <= r_use_mask;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MIN_ALIVE: prdata = {27'b0, r_min_alive};
            REG_USE_MASK:  prdata = {24'b0, r_use_mask};
            default:       prdata = '0;
        endcase
    end

    spl_front #(
        .MAX_SHARDS (MAX_SHARDS),
        .NUM_TYPES  (NUM_TYPES)
    ) u_front (
        .i_s_valid  (s_axis_tvalid),
        .i_s_data   (s_axis_tdata),
        .i_s_user   (s_axis_tuser),
        .i_use_mask (r_use_mask),
        .i_q_full   (w_q_full),
        .o_s_ready  (s_axis_tready),
        .o_push     (w_push),
        .o_entry    (w_push_entry)
    );

    spl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry)
    );

    spl_back #(
        .MAX_PEERS  (MAX_PEERS),
        .MAX_SHARDS (MAX_SHARDS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_min_alive (r_min_alive),
        .i_q_valid   (w_q_valid),
        .i_q_entry   (w_q_entry),
        .o_q_pop     (w_q_pop),
        .i_m_ready   (m_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .o_m_type    (w_type),
        .o_m_shard   (w_shard),
        .o_m_peer    (w_peer),
        .o_m_nop     (m_axis_tuser),
        .o_m_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b0, w_peer, w_shard, w_type};

endmodule
